>>> hdl/tfs_pkg.sv
`timescale 1ns / 1ps
// Package for the two-level feedback scheduler: table size, codes, entry layout
// and controller states. Used by the scheduler top level and its checker.
package tfs_pkg;

  localparam int MaxProcesses = 16;
  localparam int IdxW = (MaxProcesses > 1) ? $clog2(MaxProcesses) : 1;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFull    = 2'd1;
  localparam logic [1:0] StatusNothing = 2'd2;

  localparam logic       ActionAdd = 1'b0;
  localparam logic       ActionRun = 1'b1;

  localparam logic [1:0] LevelNone = 2'd0;
  localparam logic [1:0] LevelOne  = 2'd1;
  localparam logic [1:0] LevelTwo  = 2'd2;

  localparam logic [15:0] LevelOneSlice = 16'd2;
  localparam logic [7:0]  DemotedPrio   = 8'd1;
  localparam logic [15:0] QuantumReset  = 16'd4;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] remaining;
    logic        level;
    logic [31:0] order;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StAdd,
    StScan,
    StLast,
    StUpdate
  } state_e;

endpackage

>>> hdl/two_level_feedback_scheduler.sv
`timescale 1ns / 1ps
// Two-level feedback scheduler over a process table held in one synchronous memory.
// Depends on tfs_pkg for the table size, codes, entry layout and states.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one word per item:
// action_i selects an add (proc_id_i, prio_i, burst_i) or a run of one slice.
// The output channel (out_valid_o / out_stall_i) returns exactly one word per
// item with status, ran_id, from_level, start_time, run_length and finished.
// The configuration channel (cfg_valid_i / cfg_ready_o, cfg_data_i) writes the
// level-two time quantum; it is always ready. The user writes it only while idle;
// the block itself does not enforce this. An add goes from acceptance to StAdd,
// which loads its result into the output register once the output is free. A
// run reads every table entry through the registered memory read port, one
// entry a cycle, in StScan, then passes StLast and StUpdate, which loads the
// result once the output is free. One item is in work at a time.
// A finished result sits in the output register; the block still accepts the
// next word, but holds its result until the receiver lifts out_stall_i.
// Reset clears the valid bits, time, order counter and output valid flag and
// sets the quantum to 4; the table memory itself is not cleared.
module two_level_feedback_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] proc_id_i,
  input  logic [7:0]  prio_i,
  input  logic [15:0] burst_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] ran_id_o,
  output logic [1:0]  from_level_o,
  output logic [31:0] start_time_o,
  output logic [15:0] run_length_o,
  output logic        finished_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int N = tfs_pkg::MaxProcesses;
  localparam int W = tfs_pkg::IdxW;

  tfs_pkg::state_e state_q, state_d;

  tfs_pkg::entry_t mem_q [N];
  tfs_pkg::entry_t rd_data_q;
  tfs_pkg::entry_t wr_data;
  logic [W-1:0]    rd_addr, wr_addr;
  logic            mem_we;

  logic [N-1:0]  valid_q, valid_d;
  logic [31:0]   time_q, time_d;
  logic [31:0]   order_q, order_d;
  logic [15:0]   quantum_q;

  logic [15:0]   id_q;
  logic [7:0]    prio_q;
  logic [15:0]   burst_q;

  logic [W-1:0]  scan_cnt_q, scan_cnt_d;
  logic [W-1:0]  cmp_idx_q;
  logic          cmp_vld_q, cmp_vld_d;

  logic          found1_q, found2_q;
  logic [W-1:0]  best1_idx_q, best2_idx_q;
  tfs_pkg::entry_t best1_q, best2_q;
  logic          take1, take2, scan_start;

  logic          out_valid_q, out_load;
  logic [1:0]    status_q, status_d;
  logic [15:0]   ran_id_q, ran_id_d;
  logic [1:0]    level_q, level_d;
  logic [31:0]   start_q, start_d;
  logic [15:0]   run_q, run_d;
  logic          fin_q, fin_d;
  logic          out_free, in_accept;

  logic [W-1:0]  free_idx;
  logic          table_full;

  tfs_pkg::entry_t sel;
  logic [W-1:0]  sel_idx;
  logic [15:0]   limit, run_len, rem_left;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != tfs_pkg::StIdle);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    free_idx   = '0;
    table_full = &valid_q;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    take1 = 1'b0;
    take2 = 1'b0;
    if (cmp_vld_q && valid_q[cmp_idx_q]) begin
      if (!rd_data_q.level) begin
        take1 = !found1_q || (rd_data_q.prio < best1_q.prio) ||
                ((rd_data_q.prio == best1_q.prio) && (rd_data_q.order < best1_q.order));
      end else begin
        take2 = !found2_q || (rd_data_q.remaining < best2_q.remaining) ||
                ((rd_data_q.remaining == best2_q.remaining) &&
                 (rd_data_q.order < best2_q.order));
      end
    end
  end

  always_comb begin
    sel     = found1_q ? best1_q : best2_q;
    sel_idx = found1_q ? best1_idx_q : best2_idx_q;
    limit   = found1_q ? tfs_pkg::LevelOneSlice : quantum_q;
    run_len = (sel.remaining < limit) ? sel.remaining : limit;
    rem_left = sel.remaining - run_len;
  end

  always_comb begin
    state_d    = state_q;
    rd_addr    = scan_cnt_q;
    wr_addr    = free_idx;
    wr_data    = '0;
    mem_we     = 1'b0;
    valid_d    = valid_q;
    time_d     = time_q;
    order_d    = order_q;
    scan_cnt_d = scan_cnt_q;
    cmp_vld_d  = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    status_d   = tfs_pkg::StatusOk;
    ran_id_d   = '0;
    level_d    = tfs_pkg::LevelNone;
    start_d    = '0;
    run_d      = '0;
    fin_d      = 1'b0;
    unique case (state_q)
      tfs_pkg::StIdle: begin
        if (in_accept) begin
          if (action_i == tfs_pkg::ActionRun) begin
            state_d    = tfs_pkg::StScan;
            scan_cnt_d = '0;
            scan_start = 1'b1;
          end else begin
            state_d = tfs_pkg::StAdd;
          end
        end
      end
      tfs_pkg::StAdd: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = tfs_pkg::StIdle;
          if (table_full) begin
            status_d = tfs_pkg::StatusFull;
          end else begin
            mem_we            = 1'b1;
            wr_data.id        = id_q;
            wr_data.prio      = prio_q;
            wr_data.remaining = burst_q;
            wr_data.level     = 1'b0;
            wr_data.order     = order_q;
            valid_d[free_idx] = 1'b1;
            order_d           = order_q + 32'd1;
          end
        end
      end
      tfs_pkg::StScan: begin
        cmp_vld_d  = 1'b1;
        scan_cnt_d = scan_cnt_q + W'(1);
        if (scan_cnt_q == W'(N - 1)) begin
          state_d = tfs_pkg::StLast;
        end
      end
      tfs_pkg::StLast: begin
        state_d = tfs_pkg::StUpdate;
      end
      tfs_pkg::StUpdate: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = tfs_pkg::StIdle;
          if (!found1_q && !found2_q) begin
            status_d = tfs_pkg::StatusNothing;
          end else begin
            ran_id_d  = sel.id;
            level_d   = found1_q ? tfs_pkg::LevelOne : tfs_pkg::LevelTwo;
            start_d   = time_q;
            run_d     = run_len;
            fin_d     = (rem_left == 16'd0);
            time_d    = time_q + {16'd0, run_len};
            mem_we    = 1'b1;
            wr_addr   = sel_idx;
            wr_data   = sel;
            wr_data.remaining = rem_left;
            if (rem_left == 16'd0) begin
              valid_d[sel_idx] = 1'b0;
            end else if (found1_q) begin
              wr_data.level = 1'b1;
              wr_data.prio  = tfs_pkg::DemotedPrio;
            end else begin
              wr_data.level = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = tfs_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfs_pkg::StIdle;
      valid_q     <= '0;
      time_q      <= '0;
      order_q     <= '0;
      quantum_q   <= tfs_pkg::QuantumReset;
      scan_cnt_q  <= '0;
      cmp_vld_q   <= 1'b0;
      found1_q    <= 1'b0;
      found2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      time_q     <= time_d;
      order_q    <= order_d;
      scan_cnt_q <= scan_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        quantum_q <= cfg_data_i;
      end
      if (scan_start) begin
        found1_q <= 1'b0;
        found2_q <= 1'b0;
      end else begin
        if (take1) found1_q <= 1'b1;
        if (take2) found2_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      id_q    <= proc_id_i;
      prio_q  <= prio_i;
      burst_q <= burst_i;
    end
    cmp_idx_q <= scan_cnt_q;
    if (take1) begin
      best1_q     <= rd_data_q;
      best1_idx_q <= cmp_idx_q;
    end
    if (take2) begin
      best2_q     <= rd_data_q;
      best2_idx_q <= cmp_idx_q;
    end
    if (out_load) begin
      status_q <= status_d;
      ran_id_q <= ran_id_d;
      level_q  <= level_d;
      start_q  <= start_d;
      run_q    <= run_d;
      fin_q    <= fin_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign ran_id_o     = ran_id_q;
  assign from_level_o = level_q;
  assign start_time_o = start_q;
  assign run_length_o = run_q;
  assign finished_o   = fin_q;

endmodule

>>> hdl/tfs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the two-level feedback scheduler, with its bind.
// Depends on tfs_pkg for the status and level codes and the level-one slice.
module tfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [15:0] ran_id_o,
  input logic [1:0]  from_level_o,
  input logic [31:0] start_time_o,
  input logic [15:0] run_length_o,
  input logic        finished_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled output word was dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("A second word was accepted while one was in work.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != tfs_pkg::StatusOk) |->
      (from_level_o == tfs_pkg::LevelNone) && (run_length_o == 16'd0) && !finished_o)
    else $error("A failed item reported a slice.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (from_level_o == tfs_pkg::LevelNone) |->
      (ran_id_o == 16'd0) && (start_time_o == 32'd0) && (run_length_o == 16'd0))
    else $error("A word without a slice carries slice data.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (from_level_o == tfs_pkg::LevelOne) |->
      (run_length_o <= tfs_pkg::LevelOneSlice) && (status_o == tfs_pkg::StatusOk))
    else $error("A level-one slice ran too long.");

endmodule

bind two_level_feedback_scheduler tfs_checker u_tfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .ran_id_o     (ran_id_o),
  .from_level_o (from_level_o),
  .start_time_o (start_time_o),
  .run_length_o (run_length_o),
  .finished_o   (finished_o)
);
